[src/assert_macros.svh]
// assertion macros shared by the quadtree decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define QT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// implication checked in the same cycle
`define QT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[src/qtrd_pkg.sv]
// shared types and constants of the quadtree region decoder
`default_nettype none

package qtrd_pkg;

    // output coordinate width
    localparam int OUT_W = 8;

    // configuration port
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    // symbol bit that marks a divide (three also divides)
    localparam int SYM_DIV_BIT = 1;
    // symbol bit that carries the leaf value
    localparam int SYM_VAL_BIT = 0;

    // control handed to every stack cell
    typedef struct packed {
        logic       pop;
        logic [1:0] push_n;
    } cell_ctrl_t;

    // one filled rectangle
    typedef struct packed {
        logic [OUT_W-1:0] top_row;
        logic [OUT_W-1:0] bottom_row;
        logic [OUT_W-1:0] left_col;
        logic [OUT_W-1:0] right_col;
        logic             pixel_value;
        logic             image_done;
    } result_t;

endpackage

`default_nettype wire

[src/qtrd_cell.sv]
// one stack cell: holds a pending rectangle and shifts with its neighbours
`default_nettype none

module qtrd_cell #(
    parameter int EW = 32
) (
    input  wire logic                  clk,
    input  wire qtrd_pkg::cell_ctrl_t  ctrl,
    input  wire logic [EW-1:0]         below,
    input  wire logic [EW-1:0]         feed1,
    input  wire logic [EW-1:0]         feed2,
    input  wire logic [EW-1:0]         feed3,
    output logic [EW-1:0]              entry
);
    import qtrd_pkg::*;

    logic [EW-1:0] entry_reg;
    logic [EW-1:0] entry_next;

    // pop pulls from the cell below, a push shifts down by the push count
    always_comb
    begin
        if (ctrl.pop)
        begin
            entry_next = below;
        end
        else
        begin
            unique case (ctrl.push_n)
                2'd1:    entry_next = feed1;
                2'd2:    entry_next = feed2;
                2'd3:    entry_next = feed3;
                default: entry_next = entry_reg;
            endcase
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

[src/quadtree_region_decoder.sv]
// Quadtree region decoder: one code symbol per cycle while sym_stall is low, leaves
// out as rectangles. A leaf's rectangle is registered in the output register, or in
// the skid entry behind it if the receiver stalls. The symbol rate is set by the
// split/pop update of the pending stack, a chain of STACK_DEPTH shift cells.
// A two-entry output buffer lets one result wait while the next symbol enters.
// Reset: sizes return to 1x1, the stack empties, and the next symbol starts an image.
`default_nettype none

module quadtree_region_decoder #(
    parameter int MAX_DIM     = 256,
    parameter int STACK_DEPTH = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [qtrd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [qtrd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // symbol requests
    input  wire logic                               sym_valid,
    output logic                                    sym_stall,
    input  wire logic [1:0]                         symbol,
    // rectangle requests
    output logic                                    res_valid,
    input  wire logic                               res_stall,
    output logic [qtrd_pkg::OUT_W-1:0]              top_row,
    output logic [qtrd_pkg::OUT_W-1:0]              bottom_row,
    output logic [qtrd_pkg::OUT_W-1:0]              left_col,
    output logic [qtrd_pkg::OUT_W-1:0]              right_col,
    output logic                                    pixel_value,
    output logic                                    image_done
);
    import qtrd_pkg::*;

    `include "assert_macros.svh"

    localparam int CW   = $clog2(MAX_DIM);
    localparam int EW   = 4 * CW;
    localparam int CNTW = $clog2(STACK_DEPTH + 1);
    localparam int CMPW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;

    // configuration
    logic [CFG_DATA_W-1:0] row_count_reg;
    logic [CFG_DATA_W-1:0] col_count_reg;

    // decoder state
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            in_image_reg;
    logic            in_image_next;
    logic [EW-1:0]   cur_reg;
    logic [EW-1:0]   cur_next;

    // output buffer
    logic    res_valid_reg;
    logic    res_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t res_reg;
    result_t res_next;
    result_t skid_reg;
    result_t skid_next;
    result_t res_new;

    // stack chain
    logic [EW-1:0] q [STACK_DEPTH];
    logic [EW-1:0] acc [3];
    cell_ctrl_t    ctrl;

    // working signals
    logic            fire;
    logic            divide;
    logic            res_load;
    logic            out_fire;
    logic [CW-1:0]   row_last;
    logic [CW-1:0]   col_last;
    logic [CMPW-1:0] row_ext;
    logic [CMPW-1:0] col_ext;
    logic [EW-1:0]   cur_sel;
    logic [CNTW-1:0] cnt;
    logic [CNTW-1:0] space;
    logic [CW-1:0]   ct;
    logic [CW-1:0]   cb;
    logic [CW-1:0]   cl;
    logic [CW-1:0]   cr;
    logic [CW:0]     row_sum;
    logic [CW:0]     col_sum;
    logic [CW-1:0]   rm;
    logic [CW-1:0]   cm;
    logic [CW-1:0]   rm_p1;
    logic [CW-1:0]   cm_p1;
    logic            bl_ok;
    logic            tr_ok;
    logic            br_ok;
    logic [1:0]      n_valid;
    logic [1:0]      n_push;
    logic            cur_shape_ok;

    assign cfg_ready = 1'b1;
    assign sym_stall = skid_valid_reg;
    assign fire      = sym_valid && !skid_valid_reg;
    assign divide    = symbol[SYM_DIV_BIT];
    assign out_fire  = res_valid_reg && !res_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CFG_DATA_W'(1);
            col_count_reg <= CFG_DATA_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT: row_count_reg <= cfg_data;
                REG_COL_COUNT: col_count_reg <= cfg_data;
                default:       row_count_reg <= row_count_reg;
            endcase
        end
    end

    // last row and column of a whole image, with the size clamped
    always_comb
    begin
        row_ext = CMPW'(row_count_reg);
        col_ext = CMPW'(col_count_reg);
        if (row_ext == '0)
            row_last = '0;
        else if (row_ext > CMPW'(MAX_DIM))
            row_last = CW'(MAX_DIM - 1);
        else
            row_last = CW'(row_ext - CMPW'(1));
        if (col_ext == '0)
            col_last = '0;
        else if (col_ext > CMPW'(MAX_DIM))
            col_last = CW'(MAX_DIM - 1);
        else
            col_last = CW'(col_ext - CMPW'(1));
    end

    // current rectangle: a new image starts from the whole frame
    always_comb
    begin
        if (in_image_reg)
        begin
            cur_sel = cur_reg;
            cnt     = count_reg;
        end
        else
        begin
            cur_sel = {CW'(0), row_last, CW'(0), col_last};
            cnt     = '0;
        end
        {ct, cb, cl, cr} = cur_sel;
    end

    // split at the floor midpoints, top and left halves take the extra line
    always_comb
    begin
        row_sum = {1'b0, ct} + {1'b0, cb};
        col_sum = {1'b0, cl} + {1'b0, cr};
        rm      = row_sum[CW:1];
        cm      = col_sum[CW:1];
        rm_p1   = rm + CW'(1);
        cm_p1   = cm + CW'(1);
        bl_ok   = ct < cb;
        tr_ok   = cl < cr;
        br_ok   = bl_ok && tr_ok;
        // non-empty children in push order: bottom-right, bottom-left, top-right
        acc[0]  = br_ok ? {rm_p1, cb, cm_p1, cr} :
                  bl_ok ? {rm_p1, cb, cl, cm} : {ct, rm, cm_p1, cr};
        acc[1]  = {rm_p1, cb, cl, cm};
        acc[2]  = {ct, rm, cm_p1, cr};
        n_valid = br_ok ? 2'd3 : ((bl_ok || tr_ok) ? 2'd1 : 2'd0);
        space   = CNTW'(STACK_DEPTH) - cnt;
        n_push  = (space >= CNTW'(n_valid)) ? n_valid : space[1:0];
    end

    // next decoder state and stack control
    always_comb
    begin
        count_next    = count_reg;
        in_image_next = in_image_reg;
        cur_next      = cur_reg;
        ctrl.pop      = 1'b0;
        ctrl.push_n   = 2'd0;
        if (fire)
        begin
            if (divide)
            begin
                cur_next      = {ct, rm, cl, cm};
                in_image_next = 1'b1;
                count_next    = cnt + CNTW'(n_push);
                ctrl.push_n   = n_push;
            end
            else if (cnt == '0)
            begin
                in_image_next = 1'b0;
                count_next    = '0;
                cur_next      = cur_sel;
            end
            else
            begin
                in_image_next = 1'b1;
                count_next    = cnt - CNTW'(1);
                cur_next      = q[0];
                ctrl.pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            in_image_reg <= 1'b0;
            cur_reg      <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            in_image_reg <= in_image_next;
            cur_reg      <= cur_next;
        end
    end

    // chain of stack cells, top of stack in cell zero
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [EW-1:0] below;
        logic [EW-1:0] feed1;
        logic [EW-1:0] feed2;
        logic [EW-1:0] feed3;

        if (i == STACK_DEPTH - 1)
        begin : g_last
            assign below = '0;
        end
        else
        begin : g_mid
            assign below = q[i+1];
        end

        if (i >= 1)
        begin : g_f1
            assign feed1 = q[i-1];
        end
        else
        begin : g_f1_new
            assign feed1 = acc[0];
        end

        if (i >= 2)
        begin : g_f2
            assign feed2 = q[i-2];
        end
        else
        begin : g_f2_new
            assign feed2 = acc[1-i];
        end

        if (i >= 3)
        begin : g_f3
            assign feed3 = q[i-3];
        end
        else
        begin : g_f3_new
            assign feed3 = acc[2-i];
        end

        qtrd_cell #(
            .EW (EW)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .below (below),
            .feed1 (feed1),
            .feed2 (feed2),
            .feed3 (feed3),
            .entry (q[i])
        );
    end

    // leaf result
    always_comb
    begin
        res_load            = fire && !divide;
        res_new.top_row     = OUT_W'(ct);
        res_new.bottom_row  = OUT_W'(cb);
        res_new.left_col    = OUT_W'(cl);
        res_new.right_col   = OUT_W'(cr);
        res_new.pixel_value = symbol[SYM_VAL_BIT];
        res_new.image_done  = (cnt == '0);
    end

    // output register with one skid entry behind it
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        skid_valid_next = skid_valid_reg;
        res_next        = res_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                res_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_load)
        begin
            if (!res_valid_reg || out_fire)
            begin
                res_next       = res_new;
                res_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res_new;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg  <= res_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        skid_reg <= skid_next;
    end

    assign res_valid   = res_valid_reg;
    assign top_row     = res_reg.top_row;
    assign bottom_row  = res_reg.bottom_row;
    assign left_col    = res_reg.left_col;
    assign right_col   = res_reg.right_col;
    assign pixel_value = res_reg.pixel_value;
    assign image_done  = res_reg.image_done;

    // held rectangle keeps top above bottom and left before right
    assign cur_shape_ok = (cur_reg[4*CW-1:3*CW] <= cur_reg[3*CW-1:2*CW])
                       && (cur_reg[2*CW-1:CW] <= cur_reg[CW-1:0]);

    // checks on stack and output buffer
    `QT_ASSERT(a_count_bound, count_reg <= CNTW'(STACK_DEPTH), "stack count beyond depth")
    `QT_ASSERT_IMPL(a_skid_order, skid_valid_reg, res_valid_reg, "skid holds a result ahead of output")
    `QT_ASSERT_IMPL(a_idle_empty, !in_image_reg, count_reg == '0, "stack not empty between images")
    `QT_ASSERT_IMPL(a_cur_shape, in_image_reg, cur_shape_ok, "current rectangle inverted")

endmodule

`default_nettype wire

[test/quadtree_region_decoder_tb.sv]
// self-checking testbench for the quadtree region decoder
module quadtree_region_decoder_tb;
    import qtrd_pkg::*;

    localparam int MAX_DIM        = 256;
    localparam int STACK_DEPTH    = 32;
    localparam int PHASE_SEGMENTS = 4;
    localparam int SEGMENT_ITEMS  = 150;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    // code symbols
    localparam logic [1:0] SYM_ZERO       = 2'd0;
    localparam logic [1:0] SYM_ONE        = 2'd1;
    localparam logic [1:0] SYM_DIVIDE     = 2'd2;
    localparam logic [1:0] SYM_DIVIDE_ALT = 2'd3;

    typedef logic [8:0] coord_t;
    typedef logic [CFG_DATA_W-1:0] dim_t;

    typedef struct packed {
        coord_t top;
        coord_t bottom;
        coord_t left;
        coord_t right;
    } rect_t;

    // decoder state: sizes, pending rectangles, current rectangle
    typedef struct {
        dim_t        rows;
        dim_t        cols;
        rect_t       pending [STACK_DEPTH];
        int unsigned count;
        rect_t       cur;
        bit          in_image;
    } decoder_state_t;

    // fixed answer that overrides the decoder model for one request
    typedef struct {
        bit      typed;
        result_t want;
    } typed_answer_t;

    // one row of the directed table
    typedef struct {
        bit         is_cfg;
        dim_t       rows;
        dim_t       cols;
        logic [1:0] sym;
        bit         typed;
        result_t    want;
    } plan_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    dim_t                  cfg_data  = '0;
    logic                  sym_valid = 1'b0;
    logic                  sym_stall;
    logic [1:0]            symbol    = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [OUT_W-1:0]      top_row;
    logic [OUT_W-1:0]      bottom_row;
    logic [OUT_W-1:0]      left_col;
    logic [OUT_W-1:0]      right_col;
    logic                  pixel_value;
    logic                  image_done;

    decoder_state_t  decoder_model;
    decoder_state_t  code_planner;
    result_t         expected_rects [$];
    typed_answer_t   typed_answers [$];
    int unsigned     mismatch_count = 0;
    int unsigned     quiet_cycles   = 0;
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_idle_pct  = 0;
    bit              hold_request   = 1'b0;
    logic            hold_off       = 1'b0;

    quadtree_region_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sym_valid   (sym_valid),
        .sym_stall   (sym_stall),
        .symbol      (symbol),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .top_row     (top_row),
        .bottom_row  (bottom_row),
        .left_col    (left_col),
        .right_col   (right_col),
        .pixel_value (pixel_value),
        .image_done  (image_done)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // state after reset: 1x1 image, empty stack
    function automatic decoder_state_t fresh_state();
        decoder_state_t st;
        st.rows = 9'd1;
        st.cols = 9'd1;
        foreach (st.pending[i])
            st.pending[i] = '0;
        st.count    = 0;
        st.cur      = '0;
        st.in_image = 1'b0;
        return st;
    endfunction

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic coord_t span_of(dim_t v);
        if (v == '0)
            return 9'd1;
        if (v > MAX_DIM)
            return coord_t'(MAX_DIM);
        return v;
    endfunction

    // rectangle that the next symbol describes
    function automatic rect_t next_rect(decoder_state_t st);
        rect_t r;
        if (st.in_image)
            return st.cur;
        r.top    = '0;
        r.bottom = span_of(st.rows) - 9'd1;
        r.left   = '0;
        r.right  = span_of(st.cols) - 9'd1;
        return r;
    endfunction

    // push a child unless it is empty or the stack is full
    task automatic push_pending(inout decoder_state_t st, input coord_t t, b, l, r);
        if (t > b || l > r)
            return;
        if (st.count >= STACK_DEPTH)
            return;
        st.pending[st.count] = '{t, b, l, r};
        st.count++;
    endtask

    // one symbol through the decoder: split and push, or emit and pop
    task automatic decode_symbol(inout decoder_state_t st, input logic [1:0] sym,
                                 output bit emits, output result_t res);
        rect_t  cur;
        coord_t rmid;
        coord_t cmid;
        if (!st.in_image)
        begin
            st.cur      = next_rect(st);
            st.count    = 0;
            st.in_image = 1'b1;
        end
        cur   = st.cur;
        res   = '0;
        emits = 1'b0;
        if (sym[SYM_DIV_BIT])
        begin
            rmid = coord_t'((10'(cur.top) + 10'(cur.bottom)) >> 1);
            cmid = coord_t'((10'(cur.left) + 10'(cur.right)) >> 1);
            push_pending(st, rmid + 9'd1, cur.bottom, cmid + 9'd1, cur.right);
            push_pending(st, rmid + 9'd1, cur.bottom, cur.left, cmid);
            push_pending(st, cur.top, rmid, cmid + 9'd1, cur.right);
            st.cur.bottom = rmid;
            st.cur.right  = cmid;
        end
        else
        begin
            emits           = 1'b1;
            res.top_row     = cur.top[OUT_W-1:0];
            res.bottom_row  = cur.bottom[OUT_W-1:0];
            res.left_col    = cur.left[OUT_W-1:0];
            res.right_col   = cur.right[OUT_W-1:0];
            res.pixel_value = sym[SYM_VAL_BIT];
            if (st.count == 0)
            begin
                res.image_done = 1'b1;
                st.in_image    = 1'b0;
            end
            else
            begin
                st.count--;
                st.cur = st.pending[st.count];
            end
        end
    endtask

    // directed table helpers
    function automatic result_t rect(int t, int b, int l, int r, bit v, bit d);
        result_t x;
        x.top_row     = OUT_W'(t);
        x.bottom_row  = OUT_W'(b);
        x.left_col    = OUT_W'(l);
        x.right_col   = OUT_W'(r);
        x.pixel_value = v;
        x.image_done  = d;
        return x;
    endfunction

    function automatic plan_row_t sym_row(logic [1:0] sym, bit typed = 1'b0,
                                          result_t want = '0);
        plan_row_t row;
        row        = '{default: '0};
        row.sym    = sym;
        row.typed  = typed;
        row.want   = want;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(dim_t rows, dim_t cols);
        plan_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.rows   = rows;
        row.cols   = cols;
        return row;
    endfunction

    // mostly small sizes, now and then the extremes and clamped values
    function automatic dim_t pick_dim();
        case ($urandom_range(9))
            0:       return '0;
            1:       return dim_t'(MAX_DIM);
            2:       return dim_t'($urandom_range(MAX_DIM + 1, 511));
            3:       return dim_t'($urandom);
            default: return dim_t'($urandom_range(1, 12));
        endcase
    endfunction

    // well-formed code for the planned rectangle, with some noise mixed in
    function automatic logic [1:0] choose_symbol();
        rect_t r;
        r = next_rect(code_planner);
        if ($urandom_range(99) < 15)
            return 2'($urandom_range(3));
        if (r.top == r.bottom && r.left == r.right)
            return ($urandom_range(99) < 5) ? SYM_DIVIDE : 2'($urandom_range(1));
        if ($urandom_range(99) < 40)
            return ($urandom_range(9) == 0) ? SYM_DIVIDE_ALT : SYM_DIVIDE;
        return 2'($urandom_range(1));
    endfunction

    task automatic log_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // offer one symbol request and wait until it is taken
    task automatic send_symbol(input logic [1:0] sym, input bit typed = 1'b0,
                               input result_t want = '0);
        bit          plan_emits;
        result_t     plan_res;
        int unsigned idle_cycles;
        typed_answers.push_back(typed_answer_t'{typed, want});
        decode_symbol(code_planner, sym, plan_emits, plan_res);
        idle_cycles = 0;
        while ($urandom_range(99) < send_idle_pct)
            idle_cycles++;
        if (idle_cycles != 0)
        begin
            sym_valid <= 1'b0;
            repeat (idle_cycles)
                @(posedge clk);
        end
        sym_valid <= 1'b1;
        symbol    <= sym;
        do
            @(posedge clk);
        while (sym_stall);
    endtask

    // drain every expected rectangle, then let trailing divides settle
    task automatic wait_idle();
        sym_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_rects.size() != 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // write both size registers back to back
    task automatic write_sizes(input dim_t rows, input dim_t cols);
        cfg_valid <= 1'b1;
        cfg_index <= REG_ROW_COUNT;
        cfg_data  <= rows;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= REG_COL_COUNT;
        cfg_data  <= cols;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        decoder_model.rows = rows;
        decoder_model.cols = cols;
        code_planner.rows  = rows;
        code_planner.cols  = cols;
    endtask

    // receiver stalls at random, or for the whole hold-off
    always @(posedge clk)
        res_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

    // long hold-off so the decoder fills and stalls its input
    initial
    begin : receiver_hold
        wait (hold_request);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    // watchdog on cycles with no request taken anywhere
    always @(posedge clk)
    begin
        if ((sym_valid && !sym_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // compare results in order, predict rectangles for accepted symbols
    always @(posedge clk)
    begin : scoreboard
        typed_answer_t ans;
        result_t       pred;
        result_t       want;
        bit            emits;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_rects.size() == 0)
                    log_mismatch("rectangle with nothing expected");
                else
                begin
                    want = expected_rects.pop_front();
                    check_field("top_row", top_row, want.top_row);
                    check_field("bottom_row", bottom_row, want.bottom_row);
                    check_field("left_col", left_col, want.left_col);
                    check_field("right_col", right_col, want.right_col);
                    check_field("pixel_value", pixel_value, want.pixel_value);
                    check_field("image_done", image_done, want.image_done);
                end
            end
            if (sym_valid && !sym_stall)
            begin
                ans = typed_answers.pop_front();
                decode_symbol(decoder_model, symbol, emits, pred);
                if (emits)
                    expected_rects.push_back(ans.typed ? ans.want : pred);
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t plan [$];
        int        phase;
        int        seg;

        decoder_model = fresh_state();
        code_planner  = fresh_state();

        // after reset: 1x1 leaves, divide on one pixel, symbol three
        plan.push_back(sym_row(SYM_ZERO, 1'b1, rect(0, 0, 0, 0, 0, 1)));
        plan.push_back(sym_row(SYM_ONE, 1'b1, rect(0, 0, 0, 0, 1, 1)));
        plan.push_back(sym_row(SYM_DIVIDE));
        plan.push_back(sym_row(SYM_ONE, 1'b1, rect(0, 0, 0, 0, 1, 1)));
        plan.push_back(sym_row(SYM_DIVIDE_ALT));
        plan.push_back(sym_row(SYM_ZERO, 1'b1, rect(0, 0, 0, 0, 0, 1)));
        // zero rows acts as one
        plan.push_back(cfg_row(9'd0, 9'd256));
        plan.push_back(sym_row(SYM_ZERO, 1'b1, rect(0, 0, 0, 255, 0, 1)));
        // oversized counts clamp to the maximum
        plan.push_back(cfg_row(9'd511, 9'd300));
        plan.push_back(sym_row(SYM_ONE, 1'b1, rect(0, 255, 0, 255, 1, 1)));
        plan.push_back(sym_row(SYM_DIVIDE));
        plan.push_back(sym_row(SYM_ZERO, 1'b1, rect(0, 127, 0, 127, 0, 0)));
        plan.push_back(sym_row(SYM_DIVIDE));
        plan.push_back(sym_row(SYM_ONE));
        plan.push_back(sym_row(SYM_ZERO));
        plan.push_back(sym_row(SYM_ONE));
        plan.push_back(sym_row(SYM_ZERO));
        plan.push_back(sym_row(SYM_ONE));
        plan.push_back(sym_row(SYM_ZERO, 1'b1, rect(128, 255, 128, 255, 0, 1)));
        // odd sizes, then a size write in the middle of an image
        plan.push_back(cfg_row(9'd3, 9'd5));
        plan.push_back(sym_row(SYM_DIVIDE));
        plan.push_back(sym_row(SYM_ONE, 1'b1, rect(0, 1, 0, 2, 1, 0)));
        plan.push_back(cfg_row(9'd1, 9'd1));
        plan.push_back(sym_row(SYM_ZERO));
        plan.push_back(sym_row(SYM_ONE));
        plan.push_back(sym_row(SYM_ZERO));
        plan.push_back(sym_row(SYM_ONE, 1'b1, rect(0, 0, 0, 0, 1, 1)));
        // one column wide: right-hand children are empty
        plan.push_back(cfg_row(9'd256, 9'd1));
        plan.push_back(sym_row(SYM_DIVIDE));
        plan.push_back(sym_row(SYM_ZERO));
        plan.push_back(sym_row(SYM_ONE, 1'b1, rect(128, 255, 0, 0, 1, 1)));

        send_idle_pct = 21;
        recv_idle_pct <= 87;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_idle();
                write_sizes(plan[i].rows, plan[i].cols);
            end
            else
                send_symbol(plan[i].sym, plan[i].typed, plan[i].want);
        end

        // random code streams over three idling regimes
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 21;
                    recv_idle_pct <= 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_idle_pct <= 21;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            for (seg = 0; seg < PHASE_SEGMENTS; seg++)
            begin
                wait_idle();
                write_sizes(pick_dim(), pick_dim());
                // hold the receiver off while the sender keeps offering
                if (phase == 2 && seg == 0)
                    hold_request <= 1'b1;
                repeat (SEGMENT_ITEMS)
                    send_symbol(choose_symbol());
            end
        end

        // drain and watch for stray rectangles
        wait_idle();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
